// File: src/fttl_pkg.sv
`default_nettype none

package fttl_pkg;

    // Default depth of the list
    localparam int LIST_SIZE_DEF = 10;

    // Field widths of one list entry
    localparam int HOURS_W = 8;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int TIME_W  = HOURS_W + MIN_W + SEC_W;
    localparam int TAG_W   = 16;
    localparam int IDXF_W  = 4;   // read_index, rank and entry_count field width

    // Port widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Item kinds carried on s_tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // One stored entry: time packed hours:minutes:seconds, compares as a number
    typedef struct packed {
        logic [TIME_W-1:0] time_val;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // One result item, last member in the lowest bits
    typedef struct packed {
        logic [TAG_W-1:0]   out_tag;
        logic [SEC_W-1:0]   out_seconds;
        logic [MIN_W-1:0]   out_minutes;
        logic [HOURS_W-1:0] out_hours;
        logic               entry_valid;
        logic [IDXF_W-1:0]  entry_count;
        logic [IDXF_W-1:0]  rank;
        logic               accepted;
    } result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: src/fastest_times_top_list_core.sv
// Fastest-times top list: sorted list of the LIST_SIZE shortest times.
// Sequence: a read item passes ST_READ, then ST_DONE; an insert passes ST_SHIFT, which
// moves the longer entries and then writes the new one, after ST_CHECK when the list is full
// (a rejected insert goes from ST_CHECK straight to ST_DONE); ST_DONE waits on output stalls.
// Throughput: one item at a time, next taken back in ST_IDLE; bubbling moves one entry per cycle.
// Reset: asynchronous, clears the entry count and the sequencer; entry memory is not cleared.
`default_nettype none

module fastest_times_top_list_core #(
    parameter int LIST_SIZE = fttl_pkg::LIST_SIZE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // s_tdata: hours[7:0], minutes[13:8], seconds[19:14], player_tag[35:20],
    //          read_index[39:36]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fttl_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode[0]
    input  wire logic                            s_tuser,
    // m_tdata: accepted[0], rank[4:1], entry_count[8:5], entry_valid[9],
    //          out_hours[17:10], out_minutes[23:18], out_seconds[29:24],
    //          out_tag[45:30], zero[47:46]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fttl_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int IDX_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
    localparam int CNT_W = $clog2(LIST_SIZE + 1);
    localparam int CMP_W = (CNT_W > fttl_pkg::IDXF_W) ? CNT_W : fttl_pkg::IDXF_W;
    localparam int RES_W = $bits(fttl_pkg::result_t);

    // Input field unpacking
    logic [fttl_pkg::TIME_W-1:0] in_time;
    logic [fttl_pkg::TAG_W-1:0]  in_tag;
    logic [fttl_pkg::IDXF_W-1:0] in_index;

    assign in_time  = {s_tdata[7:0], s_tdata[13:8], s_tdata[19:14]};
    assign in_tag   = s_tdata[35:20];
    assign in_index = s_tdata[39:36];

    // Registers
    fttl_pkg::state_t           state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           pos_reg, pos_next;
    fttl_pkg::entry_t           new_reg, new_next;
    logic                       hit_reg, hit_next;
    logic                       res_acc_reg, res_acc_next;
    logic                       res_read_reg, res_read_next;
    fttl_pkg::entry_t           res_entry_reg, res_entry_next;
    logic                       out_valid_reg, out_valid_next;
    fttl_pkg::result_t          out_reg, out_next;

    // Entry memory: one write and one registered read per cycle
    fttl_pkg::entry_t           mem [LIST_SIZE];
    fttl_pkg::entry_t           rd_data_reg;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    fttl_pkg::entry_t           mem_wdata;
    logic [IDX_W-1:0]           mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Handy conditions
    logic in_take;
    logic out_free;
    logic list_full;
    logic read_in_range;
    logic worst_longer;
    logic shift_on;

    assign in_take       = s_tvalid && s_tready;
    assign out_free      = !out_valid_reg || m_tready;
    assign list_full     = (count_reg == CNT_W'(LIST_SIZE));
    assign read_in_range = (CMP_W'(in_index) < CMP_W'(count_reg));
    assign worst_longer  = (rd_data_reg.time_val > new_reg.time_val);
    assign shift_on      = (pos_reg != '0) && worst_longer;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fttl_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (s_tuser == fttl_pkg::MODE_READ)
                        state_next = fttl_pkg::ST_READ;
                    else if (list_full)
                        state_next = fttl_pkg::ST_CHECK;
                    else
                        state_next = fttl_pkg::ST_SHIFT;
                end
            end
            fttl_pkg::ST_CHECK:
            begin
                state_next = worst_longer ? fttl_pkg::ST_SHIFT : fttl_pkg::ST_DONE;
            end
            fttl_pkg::ST_SHIFT:
            begin
                if (!shift_on)
                    state_next = fttl_pkg::ST_DONE;
            end
            fttl_pkg::ST_READ:
            begin
                state_next = fttl_pkg::ST_DONE;
            end
            fttl_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = fttl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fttl_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        s_tready       = 1'b0;
        count_next     = count_reg;
        pos_next       = pos_reg;
        new_next       = new_reg;
        hit_next       = hit_reg;
        res_acc_next   = res_acc_reg;
        res_read_next  = res_read_reg;
        res_entry_next = res_entry_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = new_reg;
        mem_raddr      = pos_reg - 1'b1 - 1'b1;

        case (state_reg)
            fttl_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_take)
                begin
                    new_next.time_val = in_time;
                    new_next.tag      = in_tag;
                    hit_next          = read_in_range;
                    res_read_next     = (s_tuser == fttl_pkg::MODE_READ);
                    res_acc_next      = 1'b0;
                    if (s_tuser == fttl_pkg::MODE_READ)
                    begin
                        mem_raddr = IDX_W'(in_index);
                    end
                    else if (list_full)
                    begin
                        mem_raddr = IDX_W'(LIST_SIZE - 1);
                    end
                    else
                    begin
                        // append at the tail, then bubble toward the front
                        pos_next   = IDX_W'(count_reg);
                        mem_raddr  = IDX_W'(count_reg - 1'b1);
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            fttl_pkg::ST_CHECK:
            begin
                // worst entry strictly longer: replace it
                pos_next  = IDX_W'(LIST_SIZE - 1);
                mem_raddr = IDX_W'(LIST_SIZE - 1) - 1'b1;
            end
            fttl_pkg::ST_SHIFT:
            begin
                mem_we = 1'b1;
                if (shift_on)
                begin
                    // move the longer neighbor up one slot
                    mem_wdata = rd_data_reg;
                    pos_next  = pos_reg - 1'b1;
                end
                else
                begin
                    res_acc_next = 1'b1;
                end
            end
            fttl_pkg::ST_READ:
            begin
                res_entry_next = rd_data_reg;
            end
            fttl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.accepted    = res_acc_reg;
                    out_next.rank        = res_acc_reg ? fttl_pkg::IDXF_W'(pos_reg) : '0;
                    out_next.entry_count = fttl_pkg::IDXF_W'(count_reg);
                    if (res_read_reg && hit_reg)
                    begin
                        out_next.entry_valid = 1'b1;
                        out_next.out_hours   = res_entry_reg.time_val[19:12];
                        out_next.out_minutes = res_entry_reg.time_val[11:6];
                        out_next.out_seconds = res_entry_reg.time_val[5:0];
                        out_next.out_tag     = res_entry_reg.tag;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fttl_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        new_reg       <= new_next;
        hit_reg       <= hit_next;
        res_acc_reg   <= res_acc_next;
        res_read_reg  <= res_read_next;
        res_entry_reg <= res_entry_next;
        out_reg       <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(fttl_pkg::M_TDATA_W - RES_W)'(0), out_reg};

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_SIZE))
        else $error("entry count above list size");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !s_tready)
        else $error("new item taken while one is in progress");

    a_rank_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.accepted && (LIST_SIZE <= 15)) |->
            (out_reg.rank < out_reg.entry_count))
        else $error("rank outside the valid entries");

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg.accepted && out_reg.entry_valid))
        else $error("result flags both insert and read");

endmodule

`default_nettype wire

// File: sim/fastest_times_top_list_core_tb.sv
module fastest_times_top_list_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fttl_pkg::*;

    localparam int LIST_N       = LIST_SIZE_DEF;
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    // Keeps its own copy of the sorted list and the standings it should report
    class top_list_scoreboard;
        logic [TIME_W-1:0] times [LIST_N];
        logic [TAG_W-1:0]  tags  [LIST_N];
        int unsigned       valid_n;
        result_t           standings_q [$];
        int unsigned       errors;

        function new();
            valid_n = 0;
            errors  = 0;
        endfunction

        // Drop the new entry into slot pos, bubble it ahead of strictly longer times only
        function int unsigned place(int unsigned pos, logic [TIME_W-1:0] t,
                                    logic [TAG_W-1:0] tag);
            while (pos > 0 && times[pos-1] > t)
            begin
                times[pos] = times[pos-1];
                tags[pos]  = tags[pos-1];
                pos--;
            end
            times[pos] = t;
            tags[pos]  = tag;
            return pos;
        endfunction

        // Called for every accepted input item
        function void note_item(logic mode, logic [S_TDATA_W-1:0] d);
            result_t           r;
            logic [TIME_W-1:0] t;
            int unsigned       idx;
            r = '0;
            if (mode == MODE_INSERT)
            begin
                t = {d[7:0], d[13:8], d[19:14]};
                if (valid_n < LIST_N)
                begin
                    r.rank     = IDXF_W'(place(valid_n, t, d[35:20]));
                    r.accepted = 1'b1;
                    valid_n++;
                end
                else if (times[LIST_N-1] > t)
                begin
                    r.rank     = IDXF_W'(place(LIST_N - 1, t, d[35:20]));
                    r.accepted = 1'b1;
                end
            end
            else
            begin
                idx = d[39:36];
                if (idx < valid_n)
                begin
                    r.entry_valid = 1'b1;
                    r.out_hours   = times[idx][19:12];
                    r.out_minutes = times[idx][11:6];
                    r.out_seconds = times[idx][5:0];
                    r.out_tag     = tags[idx];
                end
            end
            r.entry_count = IDXF_W'(valid_n);
            standings_q.push_back(r);
        endfunction

        function void compare(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // Called for every accepted result item
        function void check_result(logic [M_TDATA_W-1:0] d);
            result_t got;
            result_t want;
            got = result_t'(d[$bits(result_t)-1:0]);
            if (standings_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual %h", $time, d);
                return;
            end
            want = standings_q.pop_front();
            compare("accepted",    want.accepted,    got.accepted);
            compare("rank",        want.rank,        got.rank);
            compare("entry_count", want.entry_count, got.entry_count);
            compare("entry_valid", want.entry_valid, got.entry_valid);
            compare("out_hours",   want.out_hours,   got.out_hours);
            compare("out_minutes", want.out_minutes, got.out_minutes);
            compare("out_seconds", want.out_seconds, got.out_seconds);
            compare("out_tag",     want.out_tag,     got.out_tag);
            compare("pad bits",    0,                d[M_TDATA_W-1:$bits(result_t)]);
        endfunction

        function int unsigned pending();
            return standings_q.size();
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = MODE_INSERT;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    top_list_scoreboard sb;
    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct     = 0;
    logic               hold_req      = 1'b0;
    logic               hold_done     = 1'b0;
    int unsigned        hold_left     = 0;
    int unsigned        quiet_cycles  = 0;
    int unsigned        items_done    = 0;

    always #10 clk = ~clk;

    fastest_times_top_list_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(logic [7:0] h, logic [5:0] m,
                                                       logic [5:0] s, logic [15:0] tag,
                                                       logic [3:0] idx);
        return {idx, tag, s, m, h};
    endfunction

    // Offer one item, optionally after a random gap; returns at the accepting edge
    task automatic send_item(logic mode, logic [S_TDATA_W-1:0] d);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(mode, d);
    endtask

    task automatic insert_time(logic [7:0] h, logic [5:0] m, logic [5:0] s,
                               logic [15:0] tag);
        send_item(MODE_INSERT, pack_item(h, m, s, tag, 4'($urandom_range(15))));
    endtask

    task automatic read_entry(logic [3:0] idx);
        send_item(MODE_READ, pack_item(8'($urandom), 6'($urandom), 6'($urandom),
                                       16'($urandom), idx));
    endtask

    // Sender pause until every outstanding result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // One random item; insert times drift downward so the full list keeps taking new ones
    task automatic random_item();
        int unsigned       pick;
        int unsigned       level;
        int unsigned       k;
        logic [7:0]        h;
        logic [TIME_W-1:0] t;
        if ($urandom_range(99) < 45)
        begin
            if ($urandom_range(99) < 80)
                read_entry(4'($urandom_range(LIST_N - 1)));
            else
                read_entry(4'($urandom_range(15)));
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                t = {8'($urandom), 6'($urandom), 6'($urandom)};
            else if (pick < 35 && sb.valid_n > 0)
            begin
                // tie with an entry already in the list
                k = $urandom_range(sb.valid_n - 1);
                t = sb.times[k];
            end
            else
            begin
                level = 255 - (items_done * 255) / RANDOM_ITEMS;
                if (level > 3)
                    h = 8'(level - $urandom_range(3));
                else
                    h = 8'($urandom_range(level));
                t = {h, 6'($urandom), 6'($urandom)};
            end
            insert_time(t[19:12], t[11:6], t[5:0], 16'($urandom));
        end
        items_done++;
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty reads, extremes, ties, filling, rejection and replacement
        read_entry(4'd0);
        read_entry(4'd15);
        insert_time(8'd255, 6'd63, 6'd63, 16'hFFFF);
        insert_time(8'd0, 6'd0, 6'd0, 16'h0000);
        insert_time(8'd10, 6'd30, 6'd30, 16'd1);
        insert_time(8'd10, 6'd30, 6'd30, 16'd2);
        insert_time(8'd5, 6'd59, 6'd59, 16'd3);
        read_entry(4'd4);
        read_entry(4'd5);
        insert_time(8'd20, 6'd0, 6'd0, 16'hA5A5);
        insert_time(8'd1, 6'd2, 6'd3, 16'h5A5A);
        insert_time(8'd255, 6'd0, 6'd0, 16'h1234);
        insert_time(8'd100, 6'd60, 6'd61, 16'h8001);
        insert_time(8'd10, 6'd30, 6'd30, 16'd4);
        // list is full now; equal to the worst is turned away
        insert_time(8'd255, 6'd63, 6'd63, 16'd5);
        insert_time(8'd255, 6'd63, 6'd62, 16'd6);
        insert_time(8'd0, 6'd0, 6'd0, 16'd7);
        read_entry(4'd0);
        read_entry(4'd1);
        read_entry(4'd9);
        read_entry(4'd10);
        read_entry(4'd15);
        insert_time(8'd200, 6'd1, 6'd1, 16'd8);
        read_entry(4'd9);

        // Random phases with different idling
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 54; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 54; end
                default: begin send_idle_pct = 26; stall_pct <= 26; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                if (phase == 0 && n == 100)
                    hold_req <= 1'b1;
                random_item();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
src/fttl_pkg.sv
src/fastest_times_top_list_core.sv
sim/fastest_times_top_list_core_tb.sv
